### sv/lsbs_pkg.sv
// Shared types and constants of the LSB steganography block.
package lsbs_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EMBED   = 2'd1,
        CMD_EXTRACT = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_BITS_PER_CHANNEL = 1'b0,
        CFG_PIXEL_COUNT      = 1'b1
    } t_cfg_idx;

    localparam logic [1:0] COMP_RED  = 2'd0;
    localparam logic [1:0] COMP_BLUE = 2'd2;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned PIX_W      = 13;

    // Component 0 is red, 1 green, 2 blue.
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        t_cmd        cmd;
        logic [11:0] pixel_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] extracted_byte;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       overflow;
    } t_out_item;

    typedef struct packed {
        logic [3:0]       eff_bits;
        logic [PIX_W-1:0] limit;
    } t_cfg;

endpackage

### sv/lsbs_in_if.sv
// Command channel: valid, ready and one command beat.
interface lsbs_in_if;
    logic                valid;
    logic                ready;
    lsbs_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/lsbs_out_if.sv
// Result channel: valid, ready and one result beat.
interface lsbs_out_if;
    logic                valid;
    logic                ready;
    lsbs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/lsbs_cfg.sv
// Configuration registers and their clamped working values.
module lsbs_cfg #(
    parameter int unsigned MAX_PIXELS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  lsbs_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [lsbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output lsbs_pkg::t_cfg                      o_cfg
);
    localparam int unsigned PIX_MAX_VAL = (1 << lsbs_pkg::PIX_W) - 1;
    localparam int unsigned CAP = (MAX_PIXELS > PIX_MAX_VAL) ? PIX_MAX_VAL : MAX_PIXELS;
    localparam logic [lsbs_pkg::PIX_W-1:0] CAP_V = lsbs_pkg::PIX_W'(CAP);

    logic [3:0]                   r_bpc;
    logic [lsbs_pkg::PIX_W-1:0]   r_pcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc  <= 4'd1;
            r_pcnt <= 13'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsbs_pkg::CFG_BITS_PER_CHANNEL: r_bpc  <= i_cfg_data[3:0];
                lsbs_pkg::CFG_PIXEL_COUNT:      r_pcnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero acts as one bit, anything above eight as eight.
    always_comb begin
        if (r_bpc == 4'd0)
            o_cfg.eff_bits = 4'd1;
        else if (r_bpc > 4'd8)
            o_cfg.eff_bits = 4'd8;
        else
            o_cfg.eff_bits = r_bpc;
        o_cfg.limit = (r_pcnt > CAP_V) ? CAP_V : r_pcnt;
    end

endmodule

### sv/lsbs_store.sv
// Pixel store: one write port, one read port with registered data.
module lsbs_store #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  lsbs_pkg::t_rgb     i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output lsbs_pkg::t_rgb     o_rdata
);
    lsbs_pkg::t_rgb mem [DEPTH];
    lsbs_pkg::t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            mem[i_waddr] <= i_wdata;
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lsbs_seq.sv
// Command sequencer: cursors, bit-serial read-modify-write and result register.
module lsbs_seq #(
    parameter int unsigned MAX_PIXELS = 4096,
    parameter int unsigned AW         = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lsbs_pkg::t_cfg  i_cfg,
    lsbs_in_if.sink         i_in,
    lsbs_out_if.source      o_out,
    output logic            o_mem_we,
    output logic [AW-1:0]   o_mem_waddr,
    output lsbs_pkg::t_rgb  o_mem_wdata,
    output logic [AW-1:0]   o_mem_raddr,
    input  lsbs_pkg::t_rgb  i_mem_rdata
);
    localparam int unsigned PW = lsbs_pkg::PIX_W;

    typedef enum logic [1:0] {S_IDLE, S_RDPX, S_BIT, S_DONE} t_state;

    t_state              r_state, n_state;
    lsbs_pkg::t_cmd      r_cmd, n_cmd;
    logic [7:0]          r_payload, n_payload;
    logic [2:0]          r_bit, n_bit;
    logic [7:0]          r_result, n_result;
    logic                r_ovf, n_ovf;
    lsbs_pkg::t_rgb      r_rgb, n_rgb;
    lsbs_pkg::t_rgb      r_pix, n_pix;
    logic                r_fresh, n_fresh;
    logic [PW-1:0]       r_epix, n_epix, r_xpix, n_xpix;
    logic [1:0]          r_ecomp, n_ecomp, r_xcomp, n_xcomp;
    logic [2:0]          r_epos, n_epos, r_xpos, n_xpos;
    logic                r_out_valid, n_out_valid;
    lsbs_pkg::t_out_item r_out, n_out;

    logic                accept, idx_ok, is_embed;
    logic [PW-1:0]       c_pix, a_pix;
    logic [1:0]          c_comp, a_comp;
    logic [2:0]          c_pos, a_pos;
    logic [3:0]          pos_inc;
    logic                pix_step;
    lsbs_pkg::t_rgb      cur, mod;

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign idx_ok      = (21'(i_in.data.pixel_index) < 21'(MAX_PIXELS));

    // Pick the cursor of the command at hand.
    always_comb begin
        is_embed = (r_state == S_IDLE) ? (i_in.data.cmd == lsbs_pkg::CMD_EMBED)
                                       : (r_cmd == lsbs_pkg::CMD_EMBED);
        c_pix  = is_embed ? r_epix  : r_xpix;
        c_comp = is_embed ? r_ecomp : r_xcomp;
        c_pos  = is_embed ? r_epos  : r_xpos;
    end

    // Step the cursor past the bit in use.
    always_comb begin
        pos_inc  = {1'b0, c_pos} + 4'd1;
        a_pix    = c_pix;
        a_comp   = c_comp;
        a_pos    = pos_inc[2:0];
        pix_step = 1'b0;
        if (pos_inc >= i_cfg.eff_bits) begin
            a_pos = 3'd0;
            if (c_comp == lsbs_pkg::COMP_BLUE) begin
                a_comp   = lsbs_pkg::COMP_RED;
                a_pix    = c_pix + PW'(1);
                pix_step = 1'b1;
            end else begin
                a_comp = c_comp + 2'd1;
            end
        end
    end

    always_comb begin
        cur = r_fresh ? i_mem_rdata : r_pix;
        mod = cur;
        if (r_cmd == lsbs_pkg::CMD_EMBED)
            mod[c_comp][c_pos] = r_payload[r_bit];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_payload   = r_payload;
        n_bit       = r_bit;
        n_result    = r_result;
        n_ovf       = r_ovf;
        n_rgb       = r_rgb;
        n_pix       = r_pix;
        n_fresh     = r_fresh;
        n_epix      = r_epix;
        n_ecomp     = r_ecomp;
        n_epos      = r_epos;
        n_xpix      = r_xpix;
        n_xcomp     = r_xcomp;
        n_xpos      = r_xpos;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(c_pix);
        o_mem_wdata = mod;
        o_mem_raddr = AW'(c_pix);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = i_in.data.cmd;
                    n_payload = i_in.data.payload_byte;
                    n_bit     = 3'd0;
                    n_result  = 8'd0;
                    n_ovf     = 1'b0;
                    n_rgb     = '0;
                    n_fresh   = 1'b1;
                    n_state   = S_DONE;
                    unique case (i_in.data.cmd)
                        lsbs_pkg::CMD_LOAD: begin
                            o_mem_we    = idx_ok;
                            o_mem_waddr = AW'(i_in.data.pixel_index);
                            o_mem_wdata = {i_in.data.blue_in, i_in.data.green_in,
                                           i_in.data.red_in};
                        end
                        lsbs_pkg::CMD_READ: begin
                            o_mem_raddr = AW'(i_in.data.pixel_index);
                            if (idx_ok)
                                n_state = S_RDPX;
                        end
                        default: begin
                            // Cursor already at the limit: drop the whole byte.
                            if (c_pix >= i_cfg.limit)
                                n_ovf = 1'b1;
                            else
                                n_state = S_BIT;
                        end
                    endcase
                end
            end

            S_RDPX: begin
                n_rgb   = i_mem_rdata;
                n_state = S_DONE;
            end

            S_BIT: begin
                n_pix   = mod;
                n_fresh = pix_step;
                if (r_cmd == lsbs_pkg::CMD_EXTRACT)
                    n_result[r_bit] = cur[c_comp][c_pos];
                // On embed, write the pixel back when the cursor leaves it or the byte ends.
                o_mem_we    = (r_cmd == lsbs_pkg::CMD_EMBED) && (pix_step || r_bit == 3'd7);
                o_mem_raddr = AW'(a_pix);
                if (is_embed) begin
                    n_epix  = a_pix;
                    n_ecomp = a_comp;
                    n_epos  = a_pos;
                end else begin
                    n_xpix  = a_pix;
                    n_xcomp = a_comp;
                    n_xpos  = a_pos;
                end
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = S_DONE;
                end else if (a_pix >= i_cfg.limit) begin
                    n_ovf   = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid          = 1'b1;
                    n_out.extracted_byte = r_result;
                    n_out.red_out        = r_rgb[0];
                    n_out.green_out      = r_rgb[1];
                    n_out.blue_out       = r_rgb[2];
                    n_out.overflow       = r_ovf;
                    n_state              = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_epix      <= '0;
            r_ecomp     <= '0;
            r_epos      <= '0;
            r_xpix      <= '0;
            r_xcomp     <= '0;
            r_xpos      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_epix      <= n_epix;
            r_ecomp     <= n_ecomp;
            r_epos      <= n_epos;
            r_xpix      <= n_xpix;
            r_xcomp     <= n_xcomp;
            r_xpos      <= n_xpos;
        end
        r_cmd     <= n_cmd;
        r_payload <= n_payload;
        r_bit     <= n_bit;
        r_result  <= n_result;
        r_ovf     <= n_ovf;
        r_rgb     <= n_rgb;
        r_pix     <= n_pix;
        r_fresh   <= n_fresh;
        r_out     <= n_out;
    end

endmodule

### sv/lsb_pixel_steganography.sv
// Top level of the LSB pixel steganography engine.
//
//   port        dir   beat contents
//   i_in        in    cmd, pixel_index, red_in, green_in, blue_in, payload_byte
//   o_out       out   extracted_byte, red_out, green_out, blue_out, overflow
//   i_cfg_*     in    register write: bits_per_channel (0), pixel_count (1)
//
// Embed and extract pass accept, eight bit steps and result (fewer bit steps at
// the pixel limit); load passes accept and result, read adds a store read step.
// One store read and one store write per cycle set the one-bit-per-cycle pace.
// Synchronous reset clears cursors and control; the store is not cleared.
// A new command is taken while the previous result still waits on o_out.
module lsb_pixel_steganography #(
    parameter int unsigned MAX_PIXELS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  lsbs_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [lsbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lsbs_in_if.sink                           i_in,
    lsbs_out_if.source                        o_out
);
    localparam int unsigned AW = $clog2(MAX_PIXELS);

    lsbs_pkg::t_cfg  cfg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    lsbs_pkg::t_rgb  mem_wdata, mem_rdata;

    lsbs_cfg #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lsbs_store #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lsbs_seq #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule
